/* sv/ita_pkg.sv */
// Package for the integer to ASCII formatter: request and result types,
// radix codes, character constants and the digit-to-character function.
// No dependencies.
package ita_pkg;

  localparam int CNT_W   = 7;
  localparam int OUT_CAP = 64;
  localparam int OCNT_W  = 6;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_HEX = 2'd1,
    RADIX_BIN = 2'd2
  } ita_radix_e;

  typedef enum logic [1:0] {
    U_IDLE,
    U_CONV,
    U_SCAN,
    U_HOLD
  } ita_ustate_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WAIT,
    S_SIGN,
    S_LPAD,
    S_DIGIT,
    S_RPAD
  } ita_state_e;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  radix_select;
    logic        is_signed;
    logic [6:0]  field_width;
    logic        zero_pad;
    logic        left_justify;
  } ita_req_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } ita_res_t;

  // digit unit status towards the emitter
  typedef struct packed {
    logic             ready;
    logic [CNT_W-1:0] ndig;
  } ita_dig_stat_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else begin
      c = CH_A + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

/* sv/integer_to_ascii_formatter.sv */
// Integer to ASCII formatter top level: request capture, sign and padding
// sequencer, registered character output. Depends on ita_pkg, ita_digit_unit.
//
//   port       dir  handshake             carries
//   req_i      in   start high, busy low  value and format options
//   res_o      out  valid_o, one cycle    one character, last marker
//
// Decimal: a shift-and-add-3 pass over VALUE_BITS bits, a zero scan of up to
// DEC_DIGITS digits, then the characters; hex and binary skip that pass and
// scan up to VALUE_BITS/4 or VALUE_BITS digits. Characters leave one a cycle.
// busy stays high until the last character is on res_o. Reset clears the
// sequencer and the strobe; no pass over storage. Results cannot be stalled.
module integer_to_ascii_formatter #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_WIDTH  = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  ita_pkg::ita_req_t req_i,
  output logic              busy,
  output logic              valid_o,
  output ita_pkg::ita_res_t res_o
);

  ita_pkg::ita_state_e state_q, state_d;
  logic [6:0]                  wid_q, wid_d;
  logic [6:0]                  pad_q, pad_d;
  logic [ita_pkg::CNT_W-1:0]   dcnt_q, dcnt_d;
  logic [ita_pkg::OCNT_W-1:0]  ocnt_q, ocnt_d;
  logic                        neg_q, neg_d;
  logic                        zpad_q, zpad_d;
  logic                        left_q, left_d;
  logic                        strobe_q, strobe_d;
  ita_pkg::ita_res_t           res_q, res_d;

  logic [63:0]           v64;
  logic [VALUE_BITS-1:0] v;
  logic                  neg_w;
  logic [VALUE_BITS-1:0] mag;
  logic [6:0]            wsat;
  logic [6:0]            pad_w;
  logic                  load;
  logic                  next_dig;
  ita_pkg::ita_dig_stat_t stat;
  logic [3:0]            digit;

  assign load  = start && (state_q == ita_pkg::S_IDLE);
  assign v64   = 64'(req_i.value);
  assign v     = v64[VALUE_BITS-1:0];
  assign neg_w = req_i.is_signed && v[VALUE_BITS-1];
  assign mag   = neg_w ? (~v) + VALUE_BITS'(1) : v;
  assign wsat  = (req_i.field_width > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : req_i.field_width;
  assign pad_w = (wid_q > stat.ndig) ? wid_q - stat.ndig : 7'd0;

  ita_digit_unit #(
    .VALUE_BITS(VALUE_BITS)
  ) u_digits (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .radix_i(ita_pkg::ita_radix_e'(req_i.radix_select)),
    .mag_i  (mag),
    .next_i (next_dig),
    .stat_o (stat),
    .digit_o(digit)
  );

  always_comb begin
    logic emit;
    logic fin;
    state_d  = state_q;
    wid_d    = wid_q;
    pad_d    = pad_q;
    dcnt_d   = dcnt_q;
    ocnt_d   = ocnt_q;
    neg_d    = neg_q;
    zpad_d   = zpad_q;
    left_d   = left_q;
    res_d    = res_q;
    strobe_d = 1'b0;
    next_dig = 1'b0;
    emit     = 1'b0;
    fin      = 1'b0;
    unique case (state_q)
      ita_pkg::S_IDLE: begin
        if (start) begin
          neg_d   = neg_w;
          zpad_d  = req_i.zero_pad;
          left_d  = req_i.left_justify;
          wid_d   = (neg_w && (wsat != 7'd0)) ? wsat - 7'd1 : wsat;
          ocnt_d  = '0;
          state_d = ita_pkg::S_WAIT;
        end
      end
      ita_pkg::S_WAIT: begin
        if (stat.ready) begin
          pad_d  = pad_w;
          dcnt_d = stat.ndig;
          if (neg_q) begin
            state_d = ita_pkg::S_SIGN;
          end else if (!left_q && (pad_w != 7'd0)) begin
            state_d = ita_pkg::S_LPAD;
          end else begin
            state_d = ita_pkg::S_DIGIT;
          end
        end
      end
      ita_pkg::S_SIGN: begin
        emit           = 1'b1;
        res_d.out_char = ita_pkg::CH_MINUS;
        state_d = (!left_q && (pad_q != 7'd0)) ? ita_pkg::S_LPAD : ita_pkg::S_DIGIT;
      end
      ita_pkg::S_LPAD: begin
        emit           = 1'b1;
        res_d.out_char = zpad_q ? ita_pkg::CH_ZERO : ita_pkg::CH_SPACE;
        pad_d          = pad_q - 7'd1;
        if (pad_q == 7'd1) begin
          state_d = ita_pkg::S_DIGIT;
        end
      end
      ita_pkg::S_DIGIT: begin
        emit           = 1'b1;
        next_dig       = 1'b1;
        res_d.out_char = ita_pkg::digit_char(digit);
        dcnt_d         = dcnt_q - ita_pkg::CNT_W'(1);
        if (dcnt_q == ita_pkg::CNT_W'(1)) begin
          if (left_q && (pad_q != 7'd0)) begin
            state_d = ita_pkg::S_RPAD;
          end else begin
            fin = 1'b1;
          end
        end
      end
      ita_pkg::S_RPAD: begin
        emit           = 1'b1;
        res_d.out_char = ita_pkg::CH_SPACE;
        pad_d          = pad_q - 7'd1;
        if (pad_q == 7'd1) begin
          fin = 1'b1;
        end
      end
      default: ;
    endcase
    if (emit) begin
      strobe_d = 1'b1;
      ocnt_d   = ocnt_q + ita_pkg::OCNT_W'(1);
      // output cap reached: truncate
      if (ocnt_q == ita_pkg::OCNT_W'(ita_pkg::OUT_CAP - 1)) begin
        fin = 1'b1;
      end
      res_d.last_char = fin;
      if (fin) begin
        state_d = ita_pkg::S_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ita_pkg::S_IDLE;
      strobe_q <= 1'b0;
      pad_q    <= '0;
      dcnt_q   <= '0;
      ocnt_q   <= '0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
      pad_q    <= pad_d;
      dcnt_q   <= dcnt_d;
      ocnt_q   <= ocnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wid_q  <= wid_d;
    neg_q  <= neg_d;
    zpad_q <= zpad_d;
    left_q <= left_d;
    res_q  <= res_d;
  end

  assign busy    = (state_q != ita_pkg::S_IDLE);
  assign valid_o = strobe_q;
  assign res_o   = res_q;

endmodule

/* sv/ita_digit_unit.sv */
// Digit unit: bit-serial binary to BCD conversion (shift and add-3) or direct
// hex/binary load, then a leading-zero scan one digit per cycle.
// Depends on ita_pkg.
module ita_digit_unit #(
  parameter int VALUE_BITS = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  ita_pkg::ita_radix_e       radix_i,
  input  logic [VALUE_BITS-1:0]     mag_i,
  input  logic                      next_i,
  output ita_pkg::ita_dig_stat_t    stat_o,
  output logic [3:0]                digit_o
);

  localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int DIGW       = 4 * DEC_DIGITS;
  localparam int CW         = $clog2(VALUE_BITS + 1);

  ita_pkg::ita_ustate_e ust_q, ust_d;
  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [DIGW-1:0]       dig_q, dig_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic                  isbin_q, isbin_d;

  logic [DIGW-1:0] adj;
  logic [DIGW-1:0] dig_sh;
  logic            top_zero;

  always_comb begin
    for (int k = 0; k < DEC_DIGITS; k++) begin
      adj[4*k +: 4] = (dig_q[4*k +: 4] >= 4'd5) ? dig_q[4*k +: 4] + 4'd3 : dig_q[4*k +: 4];
    end
  end

  assign dig_sh   = isbin_q ? (dig_q << 1) : (dig_q << 4);
  assign top_zero = isbin_q ? !dig_q[DIGW-1] : (dig_q[DIGW-1 -: 4] == 4'd0);

  always_comb begin
    ust_d   = ust_q;
    bin_d   = bin_q;
    dig_d   = dig_q;
    cnt_d   = cnt_q;
    isbin_d = isbin_q;
    if (load_i) begin
      bin_d = mag_i;
      unique case (radix_i)
        ita_pkg::RADIX_HEX: begin
          dig_d   = DIGW'(mag_i) << (DIGW - 4 * HEX_DIGITS);
          cnt_d   = CW'(HEX_DIGITS);
          isbin_d = 1'b0;
          ust_d   = ita_pkg::U_SCAN;
        end
        ita_pkg::RADIX_BIN: begin
          dig_d   = DIGW'(mag_i) << (DIGW - VALUE_BITS);
          cnt_d   = CW'(VALUE_BITS);
          isbin_d = 1'b1;
          ust_d   = ita_pkg::U_SCAN;
        end
        default: begin
          dig_d   = '0;
          cnt_d   = CW'(VALUE_BITS);
          isbin_d = 1'b0;
          ust_d   = ita_pkg::U_CONV;
        end
      endcase
    end else begin
      unique case (ust_q)
        ita_pkg::U_CONV: begin
          dig_d = {adj[DIGW-2:0], bin_q[VALUE_BITS-1]};
          bin_d = bin_q << 1;
          cnt_d = cnt_q - CW'(1);
          if (cnt_q == CW'(1)) begin
            cnt_d = CW'(DEC_DIGITS);
            ust_d = ita_pkg::U_SCAN;
          end
        end
        ita_pkg::U_SCAN: begin
          if (top_zero && (cnt_q > CW'(1))) begin
            dig_d = dig_sh;
            cnt_d = cnt_q - CW'(1);
          end else begin
            ust_d = ita_pkg::U_HOLD;
          end
        end
        ita_pkg::U_HOLD: begin
          if (next_i) begin
            dig_d = dig_sh;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ust_q <= ita_pkg::U_IDLE;
    end else begin
      ust_q <= ust_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q   <= bin_d;
    dig_q   <= dig_d;
    cnt_q   <= cnt_d;
    isbin_q <= isbin_d;
  end

  assign stat_o.ready = (ust_q == ita_pkg::U_HOLD);
  assign stat_o.ndig  = ita_pkg::CNT_W'(cnt_q);
  assign digit_o      = isbin_q ? {3'd0, dig_q[DIGW-1]} : dig_q[DIGW-1 -: 4];

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// Testbench for integer_to_ascii_formatter: directed and random numbers are queued,
// formatted text is predicted per request and checked character by character.
// Depends on ita_pkg and the formatter RTL.
module tb;

  localparam logic [1:0] RADIX_ALT_DEC = 2'd3;  // unnamed code, behaves as decimal
  localparam int         CYCLE_LIMIT   = 200000;
  localparam int         N_RANDOM      = 76;

  typedef struct {
    ita_pkg::ita_req_t req;
    int                gap;
    bit                drain;
  } num_item_t;

  logic              clk_i  = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start  = 1'b0;
  ita_pkg::ita_req_t req_i  = '0;
  logic              busy;
  logic              valid_o;
  ita_pkg::ita_res_t res_o;

  num_item_t         number_q[$];
  ita_pkg::ita_res_t due_chars[$];
  num_item_t         staged;
  bit                staged_ok = 1'b0;
  int                gap_left  = 0;
  int                errors    = 0;
  int                n_numbers = 0;
  int                n_chars   = 0;
  int                n_neg     = 0;
  int                n_padded  = 0;
  int                cycles    = 0;

  integer_to_ascii_formatter uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .req_i   (req_i),
    .busy    (busy),
    .valid_o (valid_o),
    .res_o   (res_o)
  );

  initial forever #5 clk_i = ~clk_i;

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic ita_pkg::ita_req_t fmt_req(logic [31:0] v, logic [1:0] rad, logic sg,
                                                logic [6:0] fw, logic zp, logic lj);
    ita_pkg::ita_req_t r;
    r.value        = v;
    r.radix_select = rad;
    r.is_signed    = sg;
    r.field_width  = fw;
    r.zero_pad     = zp;
    r.left_justify = lj;
    return r;
  endfunction

  task automatic add_num(ita_pkg::ita_req_t r, int gap, bit drain);
    num_item_t it;
    it.req   = r;
    it.gap   = gap;
    it.drain = drain;
    number_q.push_back(it);
  endtask

  // expected text of one request, appended to due_chars
  function automatic void predict_text(input ita_pkg::ita_req_t r);
    logic [31:0]       base;
    logic [31:0]       mag;
    logic [31:0]       d;
    logic [7:0]        digs[$];
    logic [7:0]        txt[$];
    logic              neg;
    int                wid;
    int                npad;
    ita_pkg::ita_res_t c;
    case (r.radix_select)
      ita_pkg::RADIX_HEX: base = 32'd16;
      ita_pkg::RADIX_BIN: base = 32'd2;
      default:            base = 32'd10;
    endcase
    neg = r.is_signed && r.value[31];
    mag = neg ? 32'd0 - r.value : r.value;
    wid = (r.field_width > 7'd64) ? 64 : int'(r.field_width);
    do begin
      d = mag % base;
      digs.push_front((d < 32'd10) ? ita_pkg::CH_ZERO + d[7:0]
                                   : ita_pkg::CH_A + d[7:0] - 8'd10);
      mag = mag / base;
    end while (mag != 32'd0);
    if (neg) begin
      txt.push_back(ita_pkg::CH_MINUS);
      if (wid > 0) wid--;
      n_neg++;
    end
    npad = (wid > digs.size()) ? wid - digs.size() : 0;
    if (npad > 0) n_padded++;
    if (!r.left_justify)
      repeat (npad) txt.push_back(r.zero_pad ? ita_pkg::CH_ZERO : ita_pkg::CH_SPACE);
    foreach (digs[i]) txt.push_back(digs[i]);
    if (r.left_justify) repeat (npad) txt.push_back(ita_pkg::CH_SPACE);
    while (txt.size() > ita_pkg::OUT_CAP) void'(txt.pop_back());
    foreach (txt[i]) begin
      c.out_char  = txt[i];
      c.last_char = (i == txt.size() - 1);
      due_chars.push_back(c);
    end
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start     <= 1'b0;
      req_i     <= '0;
      staged_ok = 1'b0;
      gap_left  = 0;
    end else begin
      if (start && !busy) begin
        predict_text(req_i);
        n_numbers++;
      end
      if (!start || !busy) begin
        if (!staged_ok && number_q.size() > 0) begin
          staged    = number_q.pop_front();
          staged_ok = 1'b1;
          gap_left  = staged.gap;
        end
        if (staged_ok && gap_left == 0 && (!staged.drain || due_chars.size() == 0)) begin
          start     <= 1'b1;
          req_i     <= staged.req;
          staged_ok = 1'b0;
        end else begin
          start <= 1'b0;
          if (staged_ok && gap_left > 0) gap_left--;
        end
      end
    end
  end

  // character monitor
  always @(posedge clk_i) begin
    ita_pkg::ita_res_t e;
    if (rst_ni && valid_o) begin
      if (due_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected character: expected none, actual 0x%02h last %0b",
                 $time, res_o.out_char, res_o.last_char);
      end else begin
        e = due_chars.pop_front();
        n_chars++;
        if (res_o.out_char !== e.out_char) begin
          errors++;
          $display("%0t: out_char expected 0x%02h actual 0x%02h",
                   $time, e.out_char, res_o.out_char);
        end
        if (res_o.last_char !== e.last_char) begin
          errors++;
          $display("%0t: last_char expected %0b actual %0b",
                   $time, e.last_char, res_o.last_char);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d characters still due", $time, due_chars.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int          g;
    logic [31:0] v;
    logic [6:0]  fw;
    // directed
    add_num(fmt_req(32'd0,        ita_pkg::RADIX_DEC, 1'b0, 7'd0,   1'b0, 1'b0), 0, 1'b0);
    add_num(fmt_req(32'hFFFFFFFF, ita_pkg::RADIX_DEC, 1'b0, 7'd0,   1'b0, 1'b0), 0, 1'b0);
    add_num(fmt_req(32'hFFFFFFFF, ita_pkg::RADIX_HEX, 1'b1, 7'd0,   1'b0, 1'b0), 3, 1'b0);
    add_num(fmt_req(32'h80000000, ita_pkg::RADIX_DEC, 1'b1, 7'd0,   1'b0, 1'b0), 0, 1'b0);
    add_num(fmt_req(32'h80000000, ita_pkg::RADIX_BIN, 1'b1, 7'd0,   1'b0, 1'b0), 1, 1'b0);
    add_num(fmt_req(32'h80000000, ita_pkg::RADIX_HEX, 1'b1, 7'd0,   1'b0, 1'b0), 0, 1'b0);
    add_num(fmt_req(32'hFFFFFFFF, ita_pkg::RADIX_BIN, 1'b0, 7'd0,   1'b0, 1'b0), 7, 1'b0);
    add_num(fmt_req(32'hDEADBEEF, ita_pkg::RADIX_HEX, 1'b0, 7'd12,  1'b1, 1'b0), 0, 1'b0);
    add_num(fmt_req(32'h01234567, ita_pkg::RADIX_HEX, 1'b0, 7'd0,   1'b0, 1'b0), 2, 1'b0);
    add_num(fmt_req(32'd123,      ita_pkg::RADIX_DEC, 1'b0, 7'd10,  1'b0, 1'b0), 0, 1'b0);
    add_num(fmt_req(32'd123,      ita_pkg::RADIX_DEC, 1'b0, 7'd10,  1'b0, 1'b1), 11, 1'b0);
    add_num(fmt_req(32'd123,      ita_pkg::RADIX_DEC, 1'b0, 7'd10,  1'b1, 1'b1), 0, 1'b0);
    add_num(fmt_req(-32'sd5,      ita_pkg::RADIX_DEC, 1'b1, 7'd6,   1'b1, 1'b0), 4, 1'b0);
    add_num(fmt_req(-32'sd5,      ita_pkg::RADIX_DEC, 1'b1, 7'd6,   1'b0, 1'b1), 0, 1'b0);
    add_num(fmt_req(-32'sd5,      ita_pkg::RADIX_DEC, 1'b1, 7'd6,   1'b0, 1'b0), 0, 1'b0);
    add_num(fmt_req(32'd99,       RADIX_ALT_DEC,      1'b0, 7'd4,   1'b1, 1'b0), 5, 1'b0);
    add_num(fmt_req(-32'sd42,     RADIX_ALT_DEC,      1'b1, 7'd0,   1'b0, 1'b0), 0, 1'b0);
    add_num(fmt_req(32'd0,        ita_pkg::RADIX_DEC, 1'b0, 7'd64,  1'b1, 1'b0), 0, 1'b0);
    add_num(fmt_req(32'h00000ABC, ita_pkg::RADIX_HEX, 1'b0, 7'd127, 1'b0, 1'b0), 9, 1'b0);
    add_num(fmt_req(32'hFFFFFFFF, ita_pkg::RADIX_BIN, 1'b1, 7'd100, 1'b1, 1'b1), 0, 1'b0);
    add_num(fmt_req(-32'sd7,      ita_pkg::RADIX_DEC, 1'b1, 7'd1,   1'b1, 1'b0), 0, 1'b0);
    add_num(fmt_req(32'h7FFFFFFF, ita_pkg::RADIX_DEC, 1'b1, 7'd65,  1'b0, 1'b1), 6, 1'b0);
    add_num(fmt_req(32'h80000000, ita_pkg::RADIX_BIN, 1'b1, 7'd64,  1'b1, 1'b0), 0, 1'b0);
    add_num(fmt_req(32'hA5A5A5A5, ita_pkg::RADIX_BIN, 1'b0, 7'd33,  1'b0, 1'b0), 0, 1'b0);
    // random, with unbroken bursts every third block of twelve
    for (int k = 0; k < N_RANDOM; k++) begin
      case ($urandom_range(0, 4))
        0: v = $urandom();
        1: v = $urandom_range(0, 20);
        2: v = {1'b1, 31'($urandom())};
        3: v = 32'd0 - $urandom_range(1, 1000);
        default: v = $urandom_range(0, 1) ? 32'h80000000 >> $urandom_range(0, 31)
                                          : 32'hFFFFFFFF >> $urandom_range(0, 31);
      endcase
      fw = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                       : 7'($urandom_range(0, 20));
      g  = ((k / 12) % 3 == 1) ? 0 : $urandom_range(0, 11);
      add_num(fmt_req(v, 2'($urandom_range(0, 3)), 1'($urandom()), fw,
                      1'($urandom()), 1'($urandom())), g, k == N_RANDOM / 2);
    end

    while (number_q.size() != 0 || staged_ok || start || due_chars.size() != 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("Formatted %0d numbers into %0d characters checked;", n_numbers, n_chars);
    $display("%0d of them printed with a minus sign, %0d padded to a field width.",
             n_neg, n_padded);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
